>>> hdl/ccc_pkg.sv
package ccc_pkg;

  localparam int MaxWaypointsDefault = 64;

  // Configuration register indexes.
  localparam logic CfgWaypointCount = 1'b0;
  localparam logic CfgHalfWidth     = 1'b1;

  localparam logic [6:0]  CountReset     = 7'd2;
  localparam logic [14:0] HalfWidthReset = 15'd512;

  // Input mode codes.
  localparam logic ModeQuery = 1'b0;
  localparam logic ModeLoad  = 1'b1;

  localparam int          CordicSteps = 14;
  localparam logic [3:0]  CordicLast  = 4'(CordicSteps - 1);
  localparam logic signed [17:0] CordicGain  = 18'sd9949;
  localparam logic signed [17:0] QuarterTurn = 18'sd16384;
  localparam logic signed [17:0] HalfTurn    = 18'sd32768;

  typedef logic signed [17:0] trig_t;
  typedef logic signed [36:0] mac_a_t;
  typedef logic signed [18:0] mac_b_t;
  typedef logic signed [55:0] mac_p_t;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic signed [17:0] cordic_atan(input logic [3:0] i);
    logic signed [17:0] r;
    unique case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // Position plus a rounded Q2.14 product, saturated to 16 bits.
  function automatic logic signed [15:0] probe_sat(input logic signed [15:0] pos,
                                                   input mac_p_t p);
    logic signed [56:0] r;
    logic signed [23:0] v;
    logic signed [15:0] o;
    r = 57'(p) + 57'sd8192;
    v = 24'(r >>> 14) + 24'(pos);
    if (v > 24'sd32767) begin
      o = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

endpackage

>>> hdl/ccc_cordic.sv
module ccc_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        heading_i,
  output logic               done_o,
  output ccc_pkg::trig_t     cos_o,
  output ccc_pkg::trig_t     sin_o
);
  import ccc_pkg::*;

  logic               run_q, done_q, flip_q;
  logic [3:0]         i_q;
  logic signed [17:0] x_q, y_q, z_q;
  logic signed [17:0] z0, xs, ys;
  logic               flip0;

  always_comb begin
    z0    = 18'(signed'(heading_i));
    flip0 = 1'b0;
    if (z0 > QuarterTurn) begin
      z0    = z0 - HalfTurn;
      flip0 = 1'b1;
    end else if (z0 < -QuarterTurn) begin
      z0    = z0 + HalfTurn;
      flip0 = 1'b1;
    end
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == CordicLast) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - cordic_atan(i_q);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + cordic_atan(i_q);
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

>>> hdl/ccc_mac.sv
module ccc_mac (
  input  logic            clk_i,
  input  ccc_pkg::mac_a_t a_i,
  input  ccc_pkg::mac_b_t b_i,
  output ccc_pkg::mac_p_t p_o
);
  import ccc_pkg::*;

  mac_p_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 56'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

>>> hdl/closed_path_corridor_check.sv
// Closed-path corridor check.
// Input channel (in_valid_i / in_stall_o) carries one request per item. A load
// request (mode 1) writes one waypoint into the table in the cycle it is
// accepted and gives no result; it is accepted whenever the block is idle.
// A query request (mode 0) rotates a probe step by the heading with an
// iterative CORDIC (one step per cycle), forms the probe point with a shared
// multiplier, then walks the closed path one segment at a time. Every
// product of the segment test goes through that one registered multiplier,
// so segments are tested one after another; a match ends the walk early.
// in_stall_o is high for the whole query.
// The result request (on_road_o, hit_segment_o) sits in an output register
// behind out_valid_o / out_stall_i. While the receiver stalls, the result is
// held, loads are still taken, and a finished query waits until the register
// is free. Configuration writes (cfg_we_i) are taken in any cycle.
// Reset clears control state and sets the waypoint count to 2 and the half
// width to 512; the waypoint table is not cleared and holds garbage until
// loaded.
module closed_path_corridor_check #(
  parameter int MaxWaypoints = ccc_pkg::MaxWaypointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [5:0]         waypoint_index_i,
  input  logic signed [15:0] waypoint_x_i,
  input  logic signed [15:0] waypoint_z_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [15:0]        heading_i,
  input  logic signed [15:0] step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               on_road_o,
  output logic [5:0]         hit_segment_o
);
  import ccc_pkg::*;

  localparam int AW = $clog2(MaxWaypoints);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CORDIC = 9'b000000010,
    S_PROBE  = 9'b000000100,
    S_RD0    = 9'b000001000,
    S_CAP0   = 9'b000010000,
    S_RDB    = 9'b000100000,
    S_CAPB   = 9'b001000000,
    S_SEG    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]         count_q;
  logic [14:0]        half_q;
  logic               out_valid_q, on_road_q, found_q;
  logic [5:0]         hit_q;
  logic [3:0]         k_q;
  logic [AW-1:0]      seg_q, last_q;

  logic signed [15:0] posx_q, posz_q, step_q, px_q, pz_q;
  logic [29:0]        hh_q;
  logic [31:0]        mem [MaxWaypoints];
  logic [31:0]        rd_q, wp0_q, a_q, b_q;
  logic signed [16:0] dx_q, dz_q, wx_q, wz_q;
  logic signed [35:0] len2_q, t_q, cr_q;
  logic [71:0]        sq_q, lim_q;

  logic               in_acc, query_acc, load_acc, closing, skip, seg_end, match_now;
  logic               out_free, cordic_done;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        b_sel;
  logic [35:0]        cr_abs;
  logic signed [39:0] t5, l40;
  trig_t              cos_v, sin_v;
  mac_a_t             mac_a;
  mac_b_t             mac_b;
  mac_p_t             mac_p;
  int                 last_int;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign query_acc = in_acc && (mode_i == ModeQuery);
  assign load_acc  = in_acc && (mode_i == ModeLoad) && (int'(waypoint_index_i) < MaxWaypoints);
  assign wr_addr   = AW'(waypoint_index_i);
  assign closing   = (seg_q == last_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  ccc_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (query_acc),
    .heading_i (heading_i),
    .done_o    (cordic_done),
    .cos_o     (cos_v),
    .sin_o     (sin_v)
  );

  ccc_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .p_o   (mac_p)
  );

  // Segment tests: the range on t and the length are checked at step 7,
  // the squared cross product against h^2 * L at step 12.
  always_comb begin
    cr_abs = cr_q[35] ? 36'(-cr_q) : 36'(cr_q);
    l40    = 40'(len2_q);
    t5     = (40'(t_q) <<< 2) + 40'(t_q);
    if (len2_q == '0) begin
      skip = 1'b1;
    end else if (closing) begin
      skip = !(t_q > 0 && t_q < len2_q);
    end else begin
      skip = (t5 < -l40) || (t5 > ((l40 <<< 2) + (l40 <<< 1)));
    end
    match_now = (k_q == 4'd12) && (sq_q <= lim_q);
    seg_end   = ((k_q == 4'd7) && skip) || (k_q == 4'd12);
    b_sel     = closing ? wp0_q : rd_q;
    rd_addr   = (state_q == S_RD0) ? '0 : AW'(seg_q + AW'(1));
    last_int  = (int'(count_q) < 2) ? 1 :
                (int'(count_q) > MaxWaypoints) ? MaxWaypoints - 1 : int'(count_q) - 1;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    unique case (state_q)
      S_PROBE: begin
        unique case (k_q)
          4'd0:    begin mac_a = 37'(cos_v); mac_b = 19'(step_q); end
          4'd1:    begin mac_a = 37'(sin_v); mac_b = 19'(step_q); end
          4'd2:    begin mac_a = {22'b0, half_q}; mac_b = {4'b0, half_q}; end
          default: ;
        endcase
      end
      S_SEG: begin
        unique case (k_q)
          4'd0:    begin mac_a = 37'(dx_q); mac_b = 19'(dx_q); end
          4'd1:    begin mac_a = 37'(dz_q); mac_b = 19'(dz_q); end
          4'd2:    begin mac_a = 37'(wx_q); mac_b = 19'(dx_q); end
          4'd3:    begin mac_a = 37'(wz_q); mac_b = 19'(dz_q); end
          4'd4:    begin mac_a = 37'(wx_q); mac_b = 19'(dz_q); end
          4'd5:    begin mac_a = 37'(wz_q); mac_b = 19'(dx_q); end
          4'd7:    begin mac_a = {1'b0, cr_abs}; mac_b = {1'b0, cr_abs[17:0]}; end
          4'd8:    begin mac_a = {1'b0, cr_abs}; mac_b = {2'b0, cr_abs[34:18]}; end
          4'd9:    begin mac_a = {1'b0, len2_q}; mac_b = {1'b0, hh_q[17:0]}; end
          4'd10:   begin mac_a = {1'b0, len2_q}; mac_b = {7'b0, hh_q[29:18]}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (query_acc) state_d = S_CORDIC;
      S_CORDIC: if (cordic_done) state_d = S_PROBE;
      S_PROBE:  if (k_q == 4'd3) state_d = S_RD0;
      S_RD0:    state_d = S_CAP0;
      S_CAP0:   state_d = S_RDB;
      S_RDB:    state_d = S_CAPB;
      S_CAPB:   state_d = S_SEG;
      S_SEG: begin
        if (seg_end) begin
          state_d = (match_now || closing) ? S_DONE : S_RDB;
        end
      end
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountReset;
      half_q      <= HalfWidthReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgWaypointCount: count_q <= cfg_data_i[6:0];
          CfgHalfWidth:     half_q  <= cfg_data_i;
          default:          ;
        endcase
      end
      // A new result may replace one that leaves in the same cycle.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mem[wr_addr] <= {waypoint_z_i, waypoint_x_i};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      posx_q  <= pos_x_i;
      posz_q  <= pos_z_i;
      step_q  <= step_i;
      last_q  <= AW'(last_int);
      found_q <= 1'b0;
    end
    if (state_q == S_CORDIC || state_q == S_CAPB) begin
      k_q <= '0;
    end else begin
      k_q <= k_q + 4'd1;
    end
    if (state_q == S_PROBE) begin
      unique case (k_q)
        4'd1:    px_q <= probe_sat(posx_q, mac_p);
        4'd2:    pz_q <= probe_sat(posz_q, mac_p);
        4'd3:    hh_q <= mac_p[29:0];
        default: ;
      endcase
    end
    if (state_q == S_CAP0) begin
      wp0_q <= rd_q;
      a_q   <= rd_q;
      seg_q <= '0;
    end
    if (state_q == S_CAPB) begin
      b_q  <= b_sel;
      dx_q <= $signed({b_sel[15], b_sel[15:0]}) - $signed({a_q[15], a_q[15:0]});
      dz_q <= $signed({b_sel[31], b_sel[31:16]}) - $signed({a_q[31], a_q[31:16]});
      wx_q <= $signed({px_q[15], px_q}) - $signed({a_q[15], a_q[15:0]});
      wz_q <= $signed({pz_q[15], pz_q}) - $signed({a_q[31], a_q[31:16]});
    end
    if (state_q == S_SEG) begin
      unique case (k_q)
        4'd1:    len2_q <= 36'(mac_p);
        4'd2:    len2_q <= len2_q + 36'(mac_p);
        4'd3:    t_q    <= 36'(mac_p);
        4'd4:    t_q    <= t_q + 36'(mac_p);
        4'd5:    cr_q   <= 36'(mac_p);
        4'd6:    cr_q   <= cr_q - 36'(mac_p);
        4'd8:    sq_q   <= {18'b0, mac_p[53:0]};
        4'd9:    sq_q   <= sq_q + ({18'b0, mac_p[53:0]} << 18);
        4'd10:   lim_q  <= {18'b0, mac_p[53:0]};
        4'd11:   lim_q  <= lim_q + ({18'b0, mac_p[53:0]} << 18);
        default: ;
      endcase
      if (seg_end && !match_now && !closing) begin
        a_q   <= b_q;
        seg_q <= seg_q + AW'(1);
      end
      if (match_now) begin
        found_q <= 1'b1;
      end
    end
    if (state_q == S_DONE && out_free) begin
      on_road_q <= found_q;
      hit_q     <= found_q ? 6'(seg_q) : 6'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign on_road_o     = on_road_q;
  assign hit_segment_o = hit_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEG) |-> (seg_q <= last_q))
    else $error("segment index ran past the last segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> (state_q == S_CORDIC))
    else $error("rotation finished outside its state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEG) |-> (k_q <= 4'd12))
    else $error("segment step counter overran");

endmodule

>>> tb/sv/tb_closed_path_corridor_check.sv
`timescale 1ns / 100ps

module tb_closed_path_corridor_check;
  import ccc_pkg::*;

  localparam int TableDepth = MaxWaypointsDefault;
  // The longest quiet stretch is the settling pause after a drain, or a
  // 64-segment query plus a receiver stall, so this limit leaves a wide margin.
  localparam int WatchdogLimit = 40000;
  localparam int RandomItems = 300;

  typedef struct packed {
    logic        mode;
    logic [5:0]  index;
    logic [15:0] wx;
    logic [15:0] wz;
    logic [15:0] px;
    logic [15:0] pz;
    logic [15:0] heading;
    logic [15:0] step;
  } request_t;

  typedef struct packed {
    logic       on_road;
    logic [5:0] segment;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_addr_i = CfgWaypointCount;
  logic [14:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = ModeQuery;
  logic [5:0] waypoint_index_i = '0;
  logic signed [15:0] waypoint_x_i = '0;
  logic signed [15:0] waypoint_z_i = '0;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_z_i = '0;
  logic [15:0] heading_i = '0;
  logic signed [15:0] step_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic on_road_o;
  logic [5:0] hit_segment_o;

  closed_path_corridor_check dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The predictor keeps its own copy of the waypoint table and registers.
  logic [31:0] path_table [TableDepth];
  logic [6:0]  path_count;
  logic [14:0] path_half_width;
  verdict_t    pending_verdicts[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          receiver_busy = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC in the block's fixed point; arithmetic shift is floor division.
  function automatic void rotate_heading(input logic [15:0] hd, output longint c,
                                         output longint s);
    longint z, x, y, nx;
    bit flip;
    int atan_units [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                            5, 3, 1};
    z = longint'($signed(hd));
    x = 9949;
    y = 0;
    flip = 1'b0;
    if (z > 16384) begin
      z -= 32768; flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768; flip = 1'b1;
    end
    for (int i = 0; i < 14; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_units[i];
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_units[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint probe_axis(logic [15:0] pos, logic [15:0] stp,
                                        longint trig);
    longint v;
    v = longint'($signed(pos)) + floor_shr(longint'($signed(stp)) * trig + 8192, 14);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic bit segment_hit(logic [31:0] a, logic [31:0] b, longint px,
                                     longint pz, bit closing, longint h);
    longint ax, az, dx, dz, wx, wz, len2, t;
    logic signed [127:0] cr, lhs, rhs;
    ax = longint'($signed(a[15:0]));
    az = longint'($signed(a[31:16]));
    dx = longint'($signed(b[15:0])) - ax;
    dz = longint'($signed(b[31:16])) - az;
    wx = px - ax;
    wz = pz - az;
    len2 = dx * dx + dz * dz;
    t = wx * dx + wz * dz;
    cr = 128'(wx * dz - wz * dx);
    if (len2 == 0) return 1'b0;
    if (closing) begin
      if (!(t > 0 && t < len2)) return 1'b0;
    end else if (5 * t < -len2 || 5 * t > 6 * len2) begin
      return 1'b0;
    end
    lhs = cr * cr;
    rhs = 128'(h * h) * 128'(len2);
    return lhs <= rhs;
  endfunction

  function automatic verdict_t corridor_verdict(request_t r);
    verdict_t v;
    longint c, s, px, pz;
    int n;
    bit closing;
    v = '0;
    n = path_count;
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    rotate_heading(r.heading, c, s);
    px = probe_axis(r.px, r.step, c);
    pz = probe_axis(r.pz, r.step, s);
    for (int i = 0; i < n; i++) begin
      closing = (i == n - 1);
      if (segment_hit(path_table[i], closing ? path_table[0] : path_table[i + 1],
                      px, pz, closing, longint'(path_half_width))) begin
        v.on_road = 1'b1;
        v.segment = 6'(i);
        break;
      end
    end
    return v;
  endfunction

  // Short gaps most of the time, with an occasional long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high after the last request of a burst until release_input.
  task automatic send_request(request_t r);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    waypoint_index_i <= r.index;
    waypoint_x_i <= r.wx;
    waypoint_z_i <= r.wz;
    pos_x_i <= r.px;
    pos_z_i <= r.pz;
    heading_i <= r.heading;
    step_i <= r.step;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The request was taken at this edge; update the predictor now.
    if (r.mode == ModeLoad) begin
      path_table[r.index] = {r.wz, r.wx};
    end else begin
      pending_verdicts.push_back(corridor_verdict(r));
    end
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_checked(request_t r, bit typed, verdict_t want);
    send_request(r);
    if (typed && r.mode == ModeQuery && pending_verdicts[$] != want) begin
      $display("%0t directed table mismatch: typed %p predicted %p", $time, want,
               pending_verdicts[$]);
      fail_count++;
    end
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    // A trailing load or a query in flight needs no more than this to settle.
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWaypointCount) path_count = val[6:0];
    else path_half_width = val;
  endtask

  function automatic request_t load_req(int idx, int x, int z);
    request_t r;
    r = '0;
    r.mode = ModeLoad;
    r.index = 6'(idx);
    r.wx = 16'(x);
    r.wz = 16'(z);
    return r;
  endfunction

  function automatic request_t query_req(int x, int z, int hd, int stp);
    request_t r;
    r = '0;
    r.mode = ModeQuery;
    r.px = 16'(x);
    r.pz = 16'(z);
    r.heading = 16'(hd);
    r.step = 16'(stp);
    return r;
  endfunction

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.on_road = on_road_o;
        got.segment = hit_segment_o;
        if (pending_verdicts.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, got);
          fail_count++;
        end else begin
          if (pending_verdicts[0].on_road !== got.on_road) begin
            $display("%0t on_road mismatch: expected %b actual %b", $time,
                     pending_verdicts[0].on_road, got.on_road);
            fail_count++;
          end
          if (pending_verdicts[0].segment !== got.segment) begin
            $display("%0t hit_segment mismatch: expected %0d actual %0d", $time,
                     pending_verdicts[0].segment, got.segment);
            fail_count++;
          end
          void'(pending_verdicts.pop_front());
        end
      end
      if (!receiver_busy) out_stall_i <= ($urandom_range(0, 3) == 0);
      else out_stall_i <= ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 199) == 0) receiver_busy <= !receiver_busy;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("closed_path_corridor_check regression: fail");
        $finish;
      end
    end
  end

  typedef struct {
    request_t req;
    bit       typed;
    verdict_t want;
  } directed_row_t;

  initial begin
    directed_row_t rows[$];
    request_t r;
    int npts;
    path_count = CountReset;
    path_half_width = HalfWidthReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Square with side 4.0 in Q8.8 at default count 2 uses only points 0 and 1.
    rows.push_back('{load_req(0, 0, 0), 0, '0});
    rows.push_back('{load_req(1, 1024, 0), 0, '0});
    rows.push_back('{load_req(2, 1024, 1024), 0, '0});
    rows.push_back('{load_req(3, 0, 1024), 0, '0});
    // Right on the first segment with no step: segment 0 matches.
    rows.push_back('{query_req(512, 0, 0, 0), 1, '{1'b1, 6'd0}});
    // Far away: nothing matches.
    rows.push_back('{query_req(-30000, 30000, 0, 0), 1, '{1'b0, 6'd0}});
    // Saturating probes at the four extremes of step and position.
    rows.push_back('{query_req(32767, 32767, 0, 32767), 0, '0});
    rows.push_back('{query_req(-32768, -32768, 32768, 32767), 0, '0});
    rows.push_back('{query_req(-32768, 32767, 16384, -32768), 0, '0});
    rows.push_back('{query_req(100, -100, 65535, -32768), 0, '0});
    rows.push_back('{query_req(256, 100, 49152, 300), 0, '0});
    // Slot 63 and extreme waypoint coordinates.
    rows.push_back('{load_req(63, -32768, 32767), 0, '0});
    rows.push_back('{load_req(62, 32767, -32768), 0, '0});
    foreach (rows[i]) send_checked(rows[i].req, rows[i].typed, rows[i].want);
    rows.delete();
    wait_drained();

    // Four-point square: closing segment and degenerate segments.
    write_register(CfgWaypointCount, 15'd4);
    write_register(CfgHalfWidth, 15'd0);
    rows.push_back('{query_req(0, 512, 0, 0), 1, '{1'b1, 6'd3}});
    rows.push_back('{query_req(0, 0, 0, 0), 0, '0});
    rows.push_back('{load_req(2, 1024, 0), 0, '0});
    rows.push_back('{query_req(1024, 0, 0, 0), 0, '0});
    rows.push_back('{query_req(900, 600, 8192, 200), 0, '0});
    foreach (rows[i]) send_checked(rows[i].req, rows[i].typed, rows[i].want);
    rows.delete();
    wait_drained();

    // Count out of range in both directions, widest half width.
    write_register(CfgWaypointCount, 15'd0);
    write_register(CfgHalfWidth, 15'd32767);
    send_checked(query_req(0, 9000, 0, 0), 0, '0);
    wait_drained();
    write_register(CfgWaypointCount, 15'd127);
    for (int i = 0; i < TableDepth; i++) begin
      send_request(load_req(i, $urandom_range(0, 65535), $urandom_range(0, 65535)));
    end
    send_checked(query_req(0, 0, 1234, 77), 0, '0);
    wait_drained();

    // Random phases: a fresh path, then mostly queries near it.
    for (int phase = 0; phase < 6; phase++) begin
      npts = (phase == 1) ? TableDepth : (phase == 0 ? 2 : $urandom_range(2, 12));
      write_register(CfgWaypointCount, 15'(npts));
      write_register(CfgHalfWidth, phase == 2 ? 15'd32767 :
                     (phase == 3 ? 15'd0 : 15'($urandom_range(16, 2000))));
      for (int i = 0; i < npts; i++) begin
        send_request(load_req(i, $signed(16'($urandom_range(0, 8000))) - 4000,
                              $signed(16'($urandom_range(0, 8000))) - 4000));
      end
      for (int k = 0; k < RandomItems / 6; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = load_req($urandom_range(npts, 63), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
        end else if ($urandom_range(0, 5) == 0) begin
          r = query_req($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else begin
          r = query_req($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                        $urandom_range(0, 65535), $urandom_range(0, 2048) - 1024);
        end
        send_request(r);
        // Sender holds off until the pipeline has drained now and then.
        if (k == 20) begin
          release_input();
          while (pending_verdicts.size() != 0) @(posedge clk_i);
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("closed_path_corridor_check regression: pass");
    end else begin
      $display("closed_path_corridor_check regression: fail");
    end
    $finish;
  end

endmodule
